[hw/rtl/cdsd_pkg.sv]
// cdsd_pkg: types, constants and calendar helper functions for the
// gregorian date minus days block; no dependencies
package cdsd_pkg;

	// field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 15;
	localparam int STAT_W  = 2;
	localparam int REM_W   = 9;

	// calendar constants
	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
	localparam logic [YEAR_W-1:0]  YEAR_CYCLE = 14'd400;
	localparam logic [REM_W-1:0]   REM_LAST   = 9'd399;
	localparam logic [REM_W-1:0]   REM_C100   = 9'd100;
	localparam logic [REM_W-1:0]   REM_C200   = 9'd200;
	localparam logic [REM_W-1:0]   REM_C300   = 9'd300;
	localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
	localparam logic [DAY_W-1:0]   DAYS_28    = 5'd28;
	localparam logic [DAY_W-1:0]   DAYS_29    = 5'd29;
	localparam logic [DAY_W-1:0]   DAYS_30    = 5'd30;
	localparam logic [DAY_W-1:0]   DAYS_31    = 5'd31;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_DATE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MOD   = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_STEP  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	// request to the year remainder unit
	typedef struct packed {
		logic              start;
		logic [YEAR_W-1:0] year;
	} yrmod_req_t;

	// answer of the year remainder unit
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [REM_W-1:0] rem;
	} yrmod_rsp_t;

	// leap year from the year modulo 400
	function automatic logic leap_of(input logic [REM_W-1:0] r);
		return (r == '0) ||
			(r != REM_C100 && r != REM_C200 && r != REM_C300 && r[1:0] == 2'b00);
	endfunction

	// days in a month, months outside the calendar give 31
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		len = DAYS_31;
		unique case (m)
			MONTH_FEB: len = leap ? DAYS_29 : DAYS_28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_30;
			default: len = DAYS_31;
		endcase
		return len;
	endfunction

endpackage

[hw/rtl/cdsd_yrmod.sv]
// cdsd_yrmod: year modulo 400 by repeated subtraction, one step a cycle
// depends on cdsd_pkg
module cdsd_yrmod (
	input  logic                clk,
	input  logic                arst_n,
	input  cdsd_pkg::yrmod_req_t req,
	output cdsd_pkg::yrmod_rsp_t rsp
);

	logic [cdsd_pkg::YEAR_W-1:0] rem_q;
	logic                        busy_q;
	logic                        below;

	assign below = rem_q < cdsd_pkg::YEAR_CYCLE;

	// busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && below) begin
			busy_q <= 1'b0;
		end
	end

	// remainder register, one subtraction a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.year;
		end else if (busy_q && !below) begin
			rem_q <= rem_q - cdsd_pkg::YEAR_CYCLE;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && below;
	assign rsp.rem  = rem_q[cdsd_pkg::REM_W-1:0];

endmodule

[hw/rtl/calendar_date_subtract_days_unit.sv]
// calendar_date_subtract_days_unit: top level, sequencer and date counters
// depends on cdsd_pkg and cdsd_yrmod
//
// Usage: one input word carries a start date (day, month, year) and a day
// count; one output word carries the date that many days earlier plus a
// status (ok, invalid start date, year underflow saturated at 1/1/0).
// Both channels use valid and stall; a word moves on a clock edge with
// valid high and stall low.
// Operation: after a word is taken the unit first reduces the year modulo
// 400 by repeated subtraction, checks the date, then walks back one day
// per cycle through the date counters; a zero count or an invalid date
// skips the walk.
// The unit takes one word at a time:
// in_stall stays high from acceptance until the result has been taken.
// The day walk is the limit, one calendar day per clock.
// Reset: arst_n clears the sequencer; the unit comes up idle and ready.
// A stalled result stays on the output ports unchanged until taken.
module calendar_date_subtract_days_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cdsd_pkg::DAY_W-1:0]    start_day,
	input  logic [cdsd_pkg::MONTH_W-1:0]  start_month,
	input  logic [cdsd_pkg::YEAR_W-1:0]   start_year,
	input  logic [cdsd_pkg::COUNT_W-1:0]  days_back,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cdsd_pkg::DAY_W-1:0]    result_day,
	output logic [cdsd_pkg::MONTH_W-1:0]  result_month,
	output logic [cdsd_pkg::YEAR_W-1:0]   result_year,
	output logic [cdsd_pkg::STAT_W-1:0]   status
);

	cdsd_pkg::state_t               state_q;
	logic [cdsd_pkg::DAY_W-1:0]     d_q;
	logic [cdsd_pkg::MONTH_W-1:0]   m_q;
	logic [cdsd_pkg::YEAR_W-1:0]    y_q;
	logic [cdsd_pkg::COUNT_W-1:0]   n_q;
	logic [cdsd_pkg::REM_W-1:0]     r400_q;
	logic [cdsd_pkg::STAT_W-1:0]    st_q;
	cdsd_pkg::yrmod_req_t           ymreq;
	cdsd_pkg::yrmod_rsp_t           ymrsp;
	logic                           accept;
	logic                           leap;
	logic                           bad_date;
	logic [cdsd_pkg::MONTH_W-1:0]   m_prev;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != cdsd_pkg::ST_IDLE;
	assign leap     = cdsd_pkg::leap_of(r400_q);
	assign m_prev   = m_q - cdsd_pkg::MONTH_JAN;

	// start date check
	assign bad_date = (m_q < cdsd_pkg::MONTH_JAN) || (m_q > cdsd_pkg::MONTH_DEC) ||
		(y_q > cdsd_pkg::YEAR_MAX) || (d_q == '0) ||
		(d_q > cdsd_pkg::month_len(m_q, leap));

	// year remainder unit
	assign ymreq.start = accept;
	assign ymreq.year  = start_year;

	cdsd_yrmod u_yrmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ymreq),
		.rsp    (ymrsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdsd_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				cdsd_pkg::ST_IDLE: begin
					if (accept) state_q <= cdsd_pkg::ST_MOD;
				end
				cdsd_pkg::ST_MOD: begin
					if (ymrsp.done) state_q <= cdsd_pkg::ST_CHECK;
				end
				cdsd_pkg::ST_CHECK: begin
					state_q <= (bad_date || n_q == '0) ? cdsd_pkg::ST_DONE
						: cdsd_pkg::ST_STEP;
				end
				cdsd_pkg::ST_STEP: begin
					if (n_q == '0 || (d_q == 5'd1 && m_q == cdsd_pkg::MONTH_JAN &&
						y_q == '0)) begin
						state_q <= cdsd_pkg::ST_DONE;
					end
				end
				cdsd_pkg::ST_DONE: begin
					if (!out_stall) state_q <= cdsd_pkg::ST_IDLE;
				end
				default: state_q <= cdsd_pkg::ST_IDLE;
			endcase
		end
	end

	// date counters, one day back per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			cdsd_pkg::ST_IDLE: begin
				if (accept) begin
					d_q  <= start_day;
					m_q  <= start_month;
					y_q  <= start_year;
					n_q  <= days_back;
					st_q <= cdsd_pkg::STAT_OK;
				end
			end
			cdsd_pkg::ST_MOD: begin
				if (ymrsp.done) r400_q <= ymrsp.rem;
			end
			cdsd_pkg::ST_CHECK: begin
				if (bad_date) st_q <= cdsd_pkg::STAT_BAD_DATE;
			end
			cdsd_pkg::ST_STEP: begin
				if (n_q != '0) begin
					n_q <= n_q - 1'b1;
					if (d_q > 5'd1) begin
						d_q <= d_q - 1'b1;
					end else if (m_q > cdsd_pkg::MONTH_JAN) begin
						m_q <= m_prev;
						d_q <= cdsd_pkg::month_len(m_prev, leap);
					end else if (y_q != '0) begin
						y_q    <= y_q - 1'b1;
						m_q    <= cdsd_pkg::MONTH_DEC;
						d_q    <= cdsd_pkg::DAYS_31;
						r400_q <= (r400_q == '0) ? cdsd_pkg::REM_LAST : r400_q - 1'b1;
					end else begin
						st_q <= cdsd_pkg::STAT_UNDERFLOW;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result word straight from the counters
	assign out_valid    = state_q == cdsd_pkg::ST_DONE;
	assign result_day   = d_q;
	assign result_month = m_q;
	assign result_year  = y_q;
	assign status       = st_q;

	// no new word while a result waits
	a_busy_when_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	// walk ends once the count is spent
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cdsd_pkg::ST_STEP && n_q == '0) |=> out_valid)
		else $error("day walk did not finish at zero count");

	// walk keeps a real date
	a_walk_date: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cdsd_pkg::ST_STEP |-> (d_q != '0 && m_q != '0 &&
			m_q <= cdsd_pkg::MONTH_DEC))
		else $error("date counters left the calendar");

	// remainder unit runs only while the sequencer waits for it
	a_mod_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cdsd_pkg::ST_MOD |-> ymrsp.busy)
		else $error("year remainder unit idle during reduction");

endmodule
